### sv/ptd_pkg.sv
package ptd_pkg;

	// Fixed field widths
	localparam int OP_W     = 2;
	localparam int PRIO_W   = 4;
	localparam int PERIOD_W = 8;
	localparam int MASK_W   = 8;
	localparam int TICK_W   = 8;

	// Slot count: default and upper limit
	localparam int NUM_TASKS_DEF = 8;
	localparam int MAX_TASKS     = 8;

	// Remainder digits retired per cycle, and cycles per slot
	localparam int DIGITS_PER_CYC = 2;
	localparam int STEPS_PER_SLOT = TICK_W / DIGITS_PER_CYC;
	localparam int STEP_W         = $clog2(STEPS_PER_SLOT);

	typedef enum logic [OP_W-1:0] {
		OP_TICK   = 2'd0,
		OP_CREATE = 2'd1,
		OP_DELETE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	// One restoring remainder step: shift in a dividend bit, subtract if it fits.
	function automatic logic [PERIOD_W-1:0] rem_step(
		input logic [PERIOD_W-1:0] rem,
		input logic                bit_in,
		input logic [PERIOD_W-1:0] divisor
	);
		logic [PERIOD_W:0] r;
		logic [PERIOD_W:0] d;
		r = {rem, bit_in};
		d = {1'b0, divisor};
		if (r >= d) begin
			r = r - d;
		end
		return r[PERIOD_W-1:0];
	endfunction

endpackage

### sv/periodic_task_dispatcher.sv
// Periodic task dispatcher. Keeps NUM_TASKS task slots (slot k serves priority k+1), each with
// an 8-bit period and a present flag, plus an 8-bit wrapping tick counter. One beat in gives one
// beat out. op tick bumps the counter and returns fire_mask, with bit k set when slot k is
// present, has a nonzero period and that period divides the new count. op create writes one
// slot (period is stored even when has_task is 0). op delete moves every higher slot down one
// place and clears the top slot. A create or delete whose priority_req is outside 1..NUM_TASKS
// changes nothing and returns bad_priority = 1; op code 3 changes nothing. tick_value always
// shows the counter after the beat. Create, delete and unused ops go from accept straight to
// the done state. A tick walks the slots in order through one shared remainder unit that
// retires two quotient digits per cycle; an empty or zero-period slot is skipped without a
// division. in_ready is high only between items; the finished result sits in an output register,
// so the next beat is taken while that result still waits for out_ready.
module periodic_task_dispatcher
	import ptd_pkg::*;
#(
	parameter int NUM_TASKS = NUM_TASKS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [OP_W-1:0]     op,
	input  logic [PRIO_W-1:0]   priority_req,
	input  logic [PERIOD_W-1:0] period,
	input  logic                has_task,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [MASK_W-1:0]   fire_mask,
	output logic [TICK_W-1:0]   tick_value,
	output logic                bad_priority
);

	localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

	// Sequencer
	state_t state_q, state_d;

	// Task table, in flops
	logic [PERIOD_W-1:0]  per_q [NUM_TASKS];
	logic [NUM_TASKS-1:0] pres_q;
	logic [TICK_W-1:0]    tick_q;

	// Scan control and shared remainder unit
	logic [IDX_W-1:0]    slot_q;
	logic [STEP_W-1:0]   step_q;
	logic [PERIOD_W-1:0] rem_q;

	// Result being built, then the output register
	logic [MASK_W-1:0]   res_mask_q;
	logic                res_bad_q;
	logic                out_valid_q;
	logic [MASK_W-1:0]   out_mask_q;
	logic [TICK_W-1:0]   out_tick_q;
	logic                out_bad_q;

	logic                in_fire;
	logic                out_free;
	logic                prio_ok;
	logic [PERIOD_W-1:0] per_cur;
	logic                skip_cur;
	logic [TICK_W-1:0]   tick_sh;
	logic [PERIOD_W-1:0] rem_in;
	logic [PERIOD_W-1:0] rem_a;
	logic [PERIOD_W-1:0] rem_b;
	logic                slot_done;
	logic                slot_last;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign prio_ok = (priority_req >= PRIO_W'(1)) && (priority_req <= PRIO_W'(NUM_TASKS));

	// Current slot into the remainder unit; dividend digits come MSB first, two per cycle
	assign per_cur   = per_q[slot_q];
	assign skip_cur  = !pres_q[slot_q] || (per_cur == '0);
	assign tick_sh   = tick_q << {step_q, 1'b0};
	assign rem_in    = (step_q == '0) ? '0 : rem_q;
	assign rem_a     = rem_step(rem_in, tick_sh[TICK_W-1], per_cur);
	assign rem_b     = rem_step(rem_a, tick_sh[TICK_W-2], per_cur);
	assign slot_done = skip_cur || (step_q == STEP_W'(STEPS_PER_SLOT - 1));
	assign slot_last = (slot_q == IDX_W'(NUM_TASKS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					state_d = (op == OP_TICK) ? ST_SCAN : ST_DONE;
				end
			end
			ST_SCAN: begin
				if (slot_done && slot_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Table and counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
			pres_q <= '0;
			for (int k = 0; k < NUM_TASKS; k++) begin
				per_q[k] <= '0;
			end
		end else if (in_fire) begin
			case (op)
				OP_TICK: begin
					tick_q <= tick_q + TICK_W'(1);
				end
				OP_CREATE: begin
					for (int k = 0; k < NUM_TASKS; k++) begin
						if (priority_req == PRIO_W'(k + 1)) begin
							per_q[k]  <= period;
							pres_q[k] <= has_task;
						end
					end
				end
				OP_DELETE: begin
					if (prio_ok) begin
						for (int k = 0; k < NUM_TASKS; k++) begin
							if (PRIO_W'(k + 1) >= priority_req) begin
								if (k + 1 < NUM_TASKS) begin
									per_q[k]  <= per_q[IDX_W'((k + 1 < NUM_TASKS) ? k + 1 : k)];
									pres_q[k] <= pres_q[IDX_W'((k + 1 < NUM_TASKS) ? k + 1 : k)];
								end else begin
									per_q[k]  <= '0;
									pres_q[k] <= 1'b0;
								end
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Scan sequencing and result build
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q     <= '0;
			step_q     <= '0;
			rem_q      <= '0;
			res_mask_q <= '0;
			res_bad_q  <= 1'b0;
		end else if (in_fire) begin
			slot_q     <= '0;
			step_q     <= '0;
			rem_q      <= '0;
			res_mask_q <= '0;
			res_bad_q  <= ((op == OP_CREATE) || (op == OP_DELETE)) && !prio_ok;
		end else if (state_q == ST_SCAN) begin
			rem_q <= rem_b;
			if (slot_done) begin
				step_q <= '0;
				if (!skip_cur && (rem_b == '0)) begin
					res_mask_q <= res_mask_q | (MASK_W'(1) << slot_q);
				end
				if (!slot_last) begin
					slot_q <= slot_q + IDX_W'(1);
				end
			end else begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_mask_q <= res_mask_q;
			out_tick_q <= tick_q;
			out_bad_q  <= res_bad_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign fire_mask    = out_mask_q;
	assign tick_value   = out_tick_q;
	assign bad_priority = out_bad_q;

`ifndef SYNTHESIS
	a_tick_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && op == OP_TICK) |=> (tick_q == $past(tick_q) + TICK_W'(1)))
		else $error("tick counter did not advance on tick");

	a_tick_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && op != OP_TICK) |=> (tick_q == $past(tick_q)))
		else $error("tick counter moved on a non-tick item");

	a_bad_nomask: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && bad_priority) |-> (fire_mask == '0))
		else $error("bad priority result carries fire bits");

	a_mask_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((fire_mask >> NUM_TASKS) == '0))
		else $error("fire bit set above the slot count");
`endif

endmodule
